// ===== hw/rtl/occ_pkg.sv =====
// ----------------------------------------------------------------------------
// occ_pkg
// Shared widths, constants, format conversions and control structs for the
// overlap cloud cover accumulator.
// ----------------------------------------------------------------------------
package occ_pkg;

  // Fixed-point formats: cover is Q1.COVER_FRACTION_BITS, product Q1.PRODUCT_FRACTION_BITS
  localparam int unsigned COVER_FRACTION_BITS   = 16;
  localparam int unsigned PRODUCT_FRACTION_BITS = 24;

  localparam int unsigned COVER_W = COVER_FRACTION_BITS + 1;
  localparam int unsigned PROD_W  = PRODUCT_FRACTION_BITS + 1;
  // Product times a cover factor; also the divider's dividend width
  localparam int unsigned NUM_W   = PROD_W + COVER_W;
  // Divider iteration counter, able to hold PROD_W itself
  localparam int unsigned CNT_W   = $clog2(PROD_W + 1);

  // Format alignment shifts, at most one of them nonzero
  localparam int unsigned SHIFT_UP = (PRODUCT_FRACTION_BITS >= COVER_FRACTION_BITS) ?
                                     PRODUCT_FRACTION_BITS - COVER_FRACTION_BITS : 0;
  localparam int unsigned SHIFT_DN = (PRODUCT_FRACTION_BITS < COVER_FRACTION_BITS) ?
                                     COVER_FRACTION_BITS - PRODUCT_FRACTION_BITS : 0;

  localparam logic [COVER_W-1:0] COVER_ONE = COVER_W'(1) << COVER_FRACTION_BITS;
  localparam logic [PROD_W-1:0]  PROD_ONE  = PROD_W'(1) << PRODUCT_FRACTION_BITS;

  // Divider control and status
  typedef struct packed {
    logic start;
  } occ_div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } occ_div_stat_t;

  // Cover value to product format, truncating when the product is narrower
  function automatic logic [PROD_W-1:0] cover_to_product(input logic [COVER_W-1:0] c);
    logic [NUM_W-1:0] wide;
    wide = NUM_W'(c);
    wide = (wide << SHIFT_UP) >> SHIFT_DN;
    return wide[PROD_W-1:0];
  endfunction

  // Product value to cover format, truncating, saturated to full cover
  function automatic logic [COVER_W-1:0] product_to_cover(input logic [PROD_W-1:0] p);
    logic [NUM_W-1:0] wide;
    wide = NUM_W'(p);
    wide = (wide << SHIFT_DN) >> SHIFT_UP;
    if (wide > NUM_W'(COVER_ONE)) begin
      wide = NUM_W'(COVER_ONE);
    end
    return wide[COVER_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/occ_div_unit.sv =====
// ----------------------------------------------------------------------------
// occ_div_unit
// Restoring divider: one shared subtract and compare, one quotient bit per
// cycle. The quotient is known to fit PROD_W bits, so the top COVER_W bits of
// the dividend seed the partial remainder directly.
// ----------------------------------------------------------------------------
module occ_div_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  occ_pkg::occ_div_ctrl_t     ctrl_i,
  input  logic [occ_pkg::NUM_W-1:0]  dividend_i,
  input  logic [occ_pkg::COVER_W-1:0] divisor_i,
  output occ_pkg::occ_div_stat_t     stat_o,
  output logic [occ_pkg::PROD_W-1:0] quotient_o
);
  import occ_pkg::*;

  logic [COVER_W-1:0] rem_q, rem_d;
  logic [PROD_W-1:0]  quo_q, quo_d;
  logic [COVER_W-1:0] dsr_q, dsr_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;

  logic [COVER_W:0]   trial;
  logic [COVER_W:0]   diff;
  logic               take;

  // Shift in the next dividend bit and try the subtraction
  assign trial = {rem_q, quo_q[PROD_W-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign take  = (trial >= {1'b0, dsr_q});

  // Sequence the iterations
  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (ctrl_i.start) begin
      rem_d  = dividend_i[NUM_W-1 -: COVER_W];
      quo_d  = dividend_i[PROD_W-1:0];
      dsr_d  = divisor_i;
      cnt_d  = CNT_W'(PROD_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = take ? diff[COVER_W-1:0] : trial[COVER_W-1:0];
      quo_d = {quo_q[PROD_W-2:0], take};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // Datapath registers need no reset
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

endmodule

// ===== hw/rtl/overlap_cloud_cover_accumulator.sv =====
// ----------------------------------------------------------------------------
// overlap_cloud_cover_accumulator
// Maximum-random overlap cloud cover of one band of levels in a column.
// Levels enter top to bottom, one request at a time. A level marked first
// goes from its acceptance straight to the final step, then the next level
// can be accepted. Every other level, at the default Q1.24 product, runs the
// 25x17 multiply and then the restoring divider, which resolves one
// quotient bit per cycle through a single shared subtractor. A level marked
// last posts total_cover in an output register; the block can take the next
// level while that result waits, and holds in its final step only if a second
// result is due before the first is taken.
// ----------------------------------------------------------------------------
module overlap_cloud_cover_accumulator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [occ_pkg::COVER_W-1:0] cover_req_i,
  input  logic                        first_level_i,
  input  logic                        last_level_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [occ_pkg::COVER_W-1:0] total_cover_o
);
  import occ_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_START = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [PROD_W-1:0]  prod_q, prod_d;
  logic [COVER_W-1:0] prev_q, prev_d;
  logic [COVER_W-1:0] fac_q, fac_d;
  logic [COVER_W-1:0] den_q, den_d;
  logic [NUM_W-1:0]   num_q, num_d;
  logic               last_q, last_d;
  logic               oval_q, oval_d;
  logic [COVER_W-1:0] total_q, total_d;

  logic               accept;
  logic [COVER_W-1:0] cur;
  logic [COVER_W-1:0] mx;
  logic [COVER_W-1:0] mn;

  occ_div_ctrl_t      div_ctrl;
  occ_div_stat_t      div_stat;
  logic [PROD_W-1:0]  quotient;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Saturate the level's cover and form the overlap factors
  assign cur = (cover_req_i > COVER_ONE) ? COVER_ONE : cover_req_i;
  assign mx  = (prev_q > cur) ? prev_q : cur;
  assign mn  = (prev_q < (COVER_ONE - COVER_W'(1))) ? prev_q : (COVER_ONE - COVER_W'(1));

  assign div_ctrl.start = (state_q == ST_START);

  occ_div_unit u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .dividend_i (num_q),
    .divisor_i  (den_q),
    .stat_o     (div_stat),
    .quotient_o (quotient)
  );

  // Sequence one level through multiply, divide and result
  always_comb begin
    state_d = state_q;
    prod_d  = prod_q;
    prev_d  = prev_q;
    fac_d   = fac_q;
    den_d   = den_q;
    num_d   = num_q;
    last_d  = last_q;
    oval_d  = oval_q && !out_ready_i;
    total_d = total_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          prev_d = cur;
          last_d = last_level_i;
          if (first_level_i) begin
            prod_d  = cover_to_product(COVER_ONE - cur);
            state_d = ST_EMIT;
          end else begin
            fac_d   = COVER_ONE - mx;
            den_d   = COVER_ONE - mn;
            state_d = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        num_d   = NUM_W'(prod_q) * NUM_W'(fac_q);
        state_d = ST_START;
      end
      ST_START: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_stat.done) begin
          prod_d  = quotient;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!last_q) begin
          state_d = ST_IDLE;
        end else if (!oval_q || out_ready_i) begin
          oval_d  = 1'b1;
          total_d = COVER_ONE - product_to_cover(prod_q);
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      prod_q  <= PROD_ONE;
      prev_q  <= '0;
      last_q  <= 1'b0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      prod_q  <= prod_d;
      prev_q  <= prev_d;
      last_q  <= last_d;
      oval_q  <= oval_d;
    end
  end

  // Operand and result registers need no reset
  always_ff @(posedge clk_i) begin
    fac_q   <= fac_d;
    den_q   <= den_d;
    num_q   <= num_d;
    total_q <= total_d;
  end

  assign out_valid_o   = oval_q;
  assign total_cover_o = total_q;

  // Accepting a level closes the input until its work is done
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("input ready right after a level was accepted");

  // Divider finishes only while the sequencer waits for it
  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == ST_DIV))
    else $error("divider done outside the divide step");

  // Divider is never restarted mid-division
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_ctrl.start |-> !div_stat.busy)
    else $error("divider started while busy");

  // Overlap never makes the clear product grow
  a_product_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (quotient <= prod_q))
    else $error("clear product grew on a level update");

  // A result appears only out of the final step of a last level
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == ST_EMIT) && $past(last_q))
    else $error("result posted without a last level");

endmodule
